>>> rtl/dhfk_pkg.sv
// Shared types, constants and tables for the DH forward kinematics unit.
// No dependencies; every other file in rtl/ except dhfk_ram imports this package.
package dhfk_pkg;

    localparam int NUM_JOINTS_DEF = 6;
    localparam int ANGLE_BITS_DEF = 16;
    localparam int COORD_BITS_DEF = 32;

    localparam int CORDIC_STEPS = 30;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sh0_26DD_3B6A;
    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

    // Input opcode, carried on tuser
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // Input tdata layout
    localparam int IDX_LSB   = 0;
    localparam int THETA_LSB = 3;
    localparam int D_LSB     = 19;
    localparam int A_LSB     = 51;
    localparam int ALPHA_LSB = 83;
    localparam int Q_LSB     = 99;
    localparam int IN_TDATA_W  = 120;
    localparam int OUT_TDATA_W = 384;

    // Segment table word: {alpha, a, d, theta}
    localparam int SEG_W = 96;

    typedef enum logic [1:0] {
        A_CA,
        A_SA,
        A_ROT
    } asel_t;

    typedef enum logic [2:0] {
        B_SP,
        B_CP,
        B_D,
        B_NEGD,
        B_T,
        B_M
    } bsel_t;

    typedef enum logic [2:0] {
        W_M3,
        W_M4,
        W_M6,
        W_M7,
        W_T1,
        W_T2,
        W_NR,
        W_POS
    } wb_dst_t;

    typedef struct packed {
        logic       accept;
        logic       ram_rd;
        logic       ram_prev;
        logic       lat_j;
        logic       lat_a;
        logic       first_init;
        logic       cor_start;
        logic       cor_alpha;
        logic       mac_issue;
        logic       mac_first;
        logic       mac_last;
        asel_t      asel;
        bsel_t      bsel;
        logic [3:0] ri;
        logic [3:0] mi;
        logic [1:0] ti;
        wb_dst_t    dst;
        logic [3:0] widx;
        logic       commit;
        logic       emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic step_req;
        logic first_joint;
        logic last_joint;
        logic cor_done;
        logic out_free;
    } ctrl_status_t;

    // atan(2^-i) in 32-bit turn units
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'h2000_0000;
            5'd1:  v = 32'h12E4_051E;
            5'd2:  v = 32'h09FB_385B;
            5'd3:  v = 32'h0511_11D4;
            5'd4:  v = 32'h028B_0D43;
            5'd5:  v = 32'h0145_D7E1;
            5'd6:  v = 32'h00A2_F61E;
            5'd7:  v = 32'h0051_7C55;
            5'd8:  v = 32'h0028_BE53;
            5'd9:  v = 32'h0014_5F2F;
            5'd10: v = 32'h000A_2F98;
            5'd11: v = 32'h0005_17CC;
            5'd12: v = 32'h0002_8BE6;
            5'd13: v = 32'h0001_45F3;
            5'd14: v = 32'h0000_A2FA;
            5'd15: v = 32'h0000_517D;
            5'd16: v = 32'h0000_28BE;
            5'd17: v = 32'h0000_145F;
            5'd18: v = 32'h0000_0A30;
            5'd19: v = 32'h0000_0518;
            5'd20: v = 32'h0000_028C;
            5'd21: v = 32'h0000_0146;
            5'd22: v = 32'h0000_00A3;
            5'd23: v = 32'h0000_0051;
            5'd24: v = 32'h0000_0029;
            5'd25: v = 32'h0000_0014;
            5'd26: v = 32'h0000_000A;
            5'd27: v = 32'h0000_0005;
            5'd28: v = 32'h0000_0003;
            5'd29: v = 32'h0000_0001;
            default: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/dhfk_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module dhfk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/dhfk_cordic.sv
// Iterative rotation CORDIC: cos and sin of a 32-bit turn angle, Q1.30.
// Depends on dhfk_pkg (step table, gain).
module dhfk_cordic
    import dhfk_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [31:0]        angle,
    output logic               done,
    output logic signed [31:0] cos_out,
    output logic signed [31:0] sin_out
);

    localparam int IW = $clog2(CORDIC_STEPS);

    logic signed [33:0] x_reg, y_reg, z_reg;
    logic signed [33:0] x_next, y_next, z_next;
    logic [IW-1:0]      iter_reg;
    logic [1:0]         quad_reg;
    logic               busy_reg, fin_reg, done_reg;
    logic signed [31:0] cos_reg, sin_reg;

    logic [31:0]        quad_sum;
    logic [31:0]        resid;
    logic signed [34:0] c_raw, s_raw;

    assign quad_sum = angle + 32'h2000_0000;
    assign resid    = angle - {quad_sum[31:30], 30'd0};

    always_comb
    begin
        logic signed [33:0] dx, dy, at;
        dx = x_reg >>> iter_reg;
        dy = y_reg >>> iter_reg;
        at = 34'(signed'({2'b00, atan_turn(5'(iter_reg))}));
        if (!z_reg[33])
        begin
            x_next = x_reg - dy;
            y_next = y_reg + dx;
            z_next = z_reg - at;
        end
        else
        begin
            x_next = x_reg + dy;
            y_next = y_reg - dx;
            z_next = z_reg + at;
        end
    end

    // Rotate by the quadrant removed at start
    always_comb
    begin
        unique case (quad_reg)
            2'd0:
            begin
                c_raw = 35'(x_reg);
                s_raw = 35'(y_reg);
            end
            2'd1:
            begin
                c_raw = -35'(y_reg);
                s_raw = 35'(x_reg);
            end
            2'd2:
            begin
                c_raw = -35'(x_reg);
                s_raw = -35'(y_reg);
            end
            default:
            begin
                c_raw = 35'(y_reg);
                s_raw = -35'(x_reg);
            end
        endcase
    end

    function automatic logic signed [31:0] clamp_q30(input logic signed [34:0] v);
        logic signed [34:0] hi;
        hi = 35'(ONE_Q30);
        if (v > hi)
        begin
            return ONE_Q30;
        end
        else if (v < -hi)
        begin
            return -ONE_Q30;
        end
        return v[31:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
            end
            else if (busy_reg)
            begin
                iter_reg <= iter_reg + 1'b1;
                if (iter_reg == IW'(CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= 34'(signed'(resid));
            quad_reg <= quad_sum[31:30];
        end
        else if (busy_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
        if (fin_reg)
        begin
            cos_reg <= clamp_q30(c_raw);
            sin_reg <= clamp_q30(s_raw);
        end
    end

    assign done    = done_reg;
    assign cos_out = cos_reg;
    assign sin_out = sin_reg;

endmodule

>>> rtl/dhfk_datapath.sv
// Datapath: segment table, CORDIC, shared multiply-accumulate, pose and output register.
// Depends on dhfk_pkg, dhfk_ram and dhfk_cordic.
module dhfk_datapath
    import dhfk_pkg::*;
#(
    parameter int NUM_JOINTS = NUM_JOINTS_DEF,
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ctrl_cmd_t              cmd,
    output ctrl_status_t           status,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tuser,
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int RAW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
    localparam int SH  = 32 - ANGLE_BITS;
    localparam int PSW = ((COORD_BITS > 38) ? COORD_BITS : 38) + 1;
    localparam int XW  = (COORD_BITS > 32) ? COORD_BITS : 32;

    // Input fields
    logic [2:0]  in_idx;
    logic [15:0] in_theta, in_alpha, in_q;
    logic [31:0] in_d, in_a;
    logic        idx_ok;

    assign in_idx   = s_axis_tdata[IDX_LSB +: 3];
    assign in_theta = s_axis_tdata[THETA_LSB +: 16];
    assign in_d     = s_axis_tdata[D_LSB +: 32];
    assign in_a     = s_axis_tdata[A_LSB +: 32];
    assign in_alpha = s_axis_tdata[ALPHA_LSB +: 16];
    assign in_q     = s_axis_tdata[Q_LSB +: 16];
    assign idx_ok   = {1'b0, in_idx} < 4'(NUM_JOINTS);

    // Item and segment registers
    logic [2:0]         idx_reg;
    logic [15:0]        q_reg, theta_reg, alpha_reg;
    logic               last_reg;
    logic signed [31:0] d_reg, a_reg;

    logic [SEG_W-1:0] ram_rd_data;
    logic [2:0]       idx_prev;
    logic [2:0]       rd_idx;

    assign idx_prev = idx_reg - 3'd1;
    assign rd_idx   = cmd.ram_prev ? idx_prev : idx_reg;

    dhfk_ram #(
        .WIDTH (SEG_W),
        .DEPTH (NUM_JOINTS)
    ) u_seg_ram (
        .clk     (clk),
        .wr_en   (cmd.accept && (s_axis_tuser == OP_LOAD) && idx_ok),
        .wr_addr (in_idx[RAW-1:0]),
        .wr_data ({in_alpha, in_a, in_d, in_theta}),
        .rd_en   (cmd.ram_rd),
        .rd_addr (rd_idx[RAW-1:0]),
        .rd_data (ram_rd_data)
    );

    // CORDIC
    logic [31:0]        joint_sum, joint_turn, alpha_turn;
    logic               cor_done;
    logic signed [31:0] cor_cos, cor_sin;
    logic               cor_alpha_reg;

    assign joint_sum  = {16'd0, theta_reg} + {16'd0, q_reg};
    assign joint_turn = joint_sum << SH;
    assign alpha_turn = {16'd0, alpha_reg} << SH;

    dhfk_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.cor_start),
        .angle   (cmd.cor_alpha ? alpha_turn : joint_turn),
        .done    (cor_done),
        .cos_out (cor_cos),
        .sin_out (cor_sin)
    );

    // Step matrix terms and pose
    logic signed [31:0]         cp_reg, sp_reg, ca_reg, sa_reg;
    logic signed [31:0]         m3_reg, m4_reg, m6_reg, m7_reg;
    logic signed [32:0]         t1_reg, t2_reg;
    logic signed [31:0]         rot_reg [9];
    logic signed [31:0]         nr_reg  [9];
    logic signed [COORD_BITS-1:0] pos_reg [3];

    // Multiplier operands
    logic signed [31:0] a_op;
    logic signed [33:0] b_op, m_val, t_val;

    always_comb
    begin
        unique case (cmd.mi)
            4'd0:    m_val = 34'(cp_reg);
            4'd1:    m_val = -34'(sp_reg);
            4'd3:    m_val = 34'(m3_reg);
            4'd4:    m_val = 34'(m4_reg);
            4'd5:    m_val = -34'(sa_reg);
            4'd6:    m_val = 34'(m6_reg);
            4'd7:    m_val = 34'(m7_reg);
            4'd8:    m_val = 34'(ca_reg);
            default: m_val = '0;
        endcase
        unique case (cmd.ti)
            2'd0:    t_val = 34'(a_reg);
            2'd1:    t_val = 34'(t1_reg);
            default: t_val = 34'(t2_reg);
        endcase
        unique case (cmd.asel)
            A_CA:    a_op = ca_reg;
            A_SA:    a_op = sa_reg;
            A_ROT:   a_op = rot_reg[cmd.ri];
            default: a_op = '0;
        endcase
        unique case (cmd.bsel)
            B_SP:    b_op = 34'(sp_reg);
            B_CP:    b_op = 34'(cp_reg);
            B_D:     b_op = 34'(d_reg);
            B_NEGD:  b_op = -34'(d_reg);
            B_T:     b_op = t_val;
            B_M:     b_op = m_val;
            default: b_op = '0;
        endcase
    end

    // Two-stage MAC: product register, then accumulator with write-back tag
    logic signed [65:0] prod_reg;
    logic               s1_valid, s1_first, s1_last;
    wb_dst_t            s1_dst;
    logic [3:0]         s1_idx;
    logic signed [67:0] acc_reg;
    logic               s2_wb;
    wb_dst_t            s2_dst;
    logic [3:0]         s2_idx;

    logic signed [67:0] rnd_sum;
    logic signed [37:0] rnd;
    logic signed [31:0] rnd_sat;
    logic signed [PSW-1:0] pos_sum, pmax_w, pmin_w;
    logic signed [COORD_BITS-1:0] pos_new;

    assign rnd_sum = acc_reg + 68'sd536870912;
    assign rnd     = rnd_sum[67:30];

    always_comb
    begin
        if (rnd > 38'sh00_4000_0000)
        begin
            rnd_sat = ONE_Q30;
        end
        else if (rnd < -38'sh00_4000_0000)
        begin
            rnd_sat = -ONE_Q30;
        end
        else
        begin
            rnd_sat = rnd[31:0];
        end
    end

    assign pmax_w  = {{(PSW - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
    assign pmin_w  = ~pmax_w;
    assign pos_sum = PSW'(pos_reg[s2_idx[1:0]]) + PSW'(rnd);

    always_comb
    begin
        if (pos_sum > pmax_w)
        begin
            pos_new = pmax_w[COORD_BITS-1:0];
        end
        else if (pos_sum < pmin_w)
        begin
            pos_new = pmin_w[COORD_BITS-1:0];
        end
        else
        begin
            pos_new = pos_sum[COORD_BITS-1:0];
        end
    end

    function automatic logic [31:0] sat32(input logic signed [COORD_BITS-1:0] v);
        logic signed [XW-1:0] ve, hi, lo;
        ve = XW'(v);
        hi = XW'(64'sh0000_0000_7FFF_FFFF);
        lo = XW'(-64'sh0000_0000_8000_0000);
        if (ve > hi)
        begin
            return hi[31:0];
        end
        else if (ve < lo)
        begin
            return lo[31:0];
        end
        return ve[31:0];
    endfunction

    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid      <= 1'b0;
            s2_wb         <= 1'b0;
            out_valid_reg <= 1'b0;
            cor_alpha_reg <= 1'b0;
            for (int i = 0; i < 9; i++)
            begin
                rot_reg[i] <= (i % 4 == 0) ? ONE_Q30 : '0;
            end
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= '0;
            end
        end
        else
        begin
            s1_valid <= cmd.mac_issue;
            s2_wb    <= s1_valid && s1_last;
            if (cmd.cor_start)
            begin
                cor_alpha_reg <= cmd.cor_alpha;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            // Restart the pose for joint 0
            if (cmd.first_init)
            begin
                for (int i = 0; i < 9; i++)
                begin
                    rot_reg[i] <= (i % 4 == 0) ? ONE_Q30 : '0;
                end
                for (int i = 0; i < 3; i++)
                begin
                    pos_reg[i] <= '0;
                end
            end
            if (cmd.commit)
            begin
                for (int i = 0; i < 9; i++)
                begin
                    rot_reg[i] <= nr_reg[i];
                end
            end
            if (s2_wb && (s2_dst == W_POS))
            begin
                pos_reg[s2_idx[1:0]] <= pos_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            idx_reg  <= in_idx;
            q_reg    <= in_q;
            last_reg <= s_axis_tlast;
        end
        if (cmd.lat_j)
        begin
            theta_reg <= ram_rd_data[15:0];
            d_reg     <= ram_rd_data[47:16];
        end
        if (cmd.lat_a)
        begin
            a_reg     <= ram_rd_data[79:48];
            alpha_reg <= ram_rd_data[95:80];
        end
        if (cmd.first_init)
        begin
            a_reg  <= '0;
            ca_reg <= ONE_Q30;
            sa_reg <= '0;
        end
        if (cor_done)
        begin
            if (cor_alpha_reg)
            begin
                ca_reg <= cor_cos;
                sa_reg <= cor_sin;
            end
            else
            begin
                cp_reg <= cor_cos;
                sp_reg <= cor_sin;
            end
        end

        prod_reg <= 66'(a_op) * 66'(b_op);
        s1_first <= cmd.mac_first;
        s1_last  <= cmd.mac_last;
        s1_dst   <= cmd.dst;
        s1_idx   <= cmd.widx;

        if (s1_valid)
        begin
            acc_reg <= (s1_first ? 68'sd0 : acc_reg) + 68'(prod_reg);
        end
        s2_dst <= s1_dst;
        s2_idx <= s1_idx;

        if (s2_wb)
        begin
            unique case (s2_dst)
                W_M3:    m3_reg <= rnd[31:0];
                W_M4:    m4_reg <= rnd[31:0];
                W_M6:    m6_reg <= rnd[31:0];
                W_M7:    m7_reg <= rnd[31:0];
                W_T1:    t1_reg <= rnd[32:0];
                W_T2:    t2_reg <= rnd[32:0];
                W_NR:    nr_reg[s2_idx] <= rnd_sat;
                default: ;
            endcase
        end

        if (cmd.emit)
        begin
            for (int i = 0; i < 9; i++)
            begin
                out_data_reg[32*i +: 32] <= rot_reg[i];
            end
            for (int i = 0; i < 3; i++)
            begin
                out_data_reg[32*(9+i) +: 32] <= sat32(pos_reg[i]);
            end
        end
    end

    assign status.step_req    = (s_axis_tuser == OP_STEP) && idx_ok;
    assign status.first_joint = (idx_reg == 3'd0);
    assign status.last_joint  = last_reg;
    assign status.cor_done    = cor_done;
    assign status.out_free    = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

>>> rtl/dhfk_ctrl.sv
// Controller: sequences table reads, CORDIC runs, MAC issue and pose commit.
// Depends on dhfk_pkg (command and status structs).
module dhfk_ctrl
    import dhfk_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_J,
        ST_RD_A,
        ST_LAT_A,
        ST_COR_J,
        ST_WAIT_J,
        ST_COR_A,
        ST_WAIT_A,
        ST_PROD,
        ST_PDRAIN,
        ST_ROW,
        ST_RDRAIN,
        ST_COMMIT,
        ST_EMIT
    } state_t;

    state_t     state_reg;
    logic [2:0] pcnt_reg;
    logic [1:0] row_reg, dot_reg, k_reg;
    logic       drain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pcnt_reg  <= '0;
            row_reg   <= '0;
            dot_reg   <= '0;
            k_reg     <= '0;
            drain_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid && status.step_req)
                    begin
                        state_reg <= ST_RD_J;
                    end
                end
                ST_RD_J:  state_reg <= ST_RD_A;
                ST_RD_A:  state_reg <= ST_LAT_A;
                ST_LAT_A: state_reg <= ST_COR_J;
                ST_COR_J: state_reg <= ST_WAIT_J;
                ST_WAIT_J:
                begin
                    if (status.cor_done)
                    begin
                        pcnt_reg  <= '0;
                        state_reg <= status.first_joint ? ST_PROD : ST_COR_A;
                    end
                end
                ST_COR_A: state_reg <= ST_WAIT_A;
                ST_WAIT_A:
                begin
                    if (status.cor_done)
                    begin
                        pcnt_reg  <= '0;
                        state_reg <= ST_PROD;
                    end
                end
                ST_PROD:
                begin
                    pcnt_reg <= pcnt_reg + 3'd1;
                    if (pcnt_reg == 3'd5)
                    begin
                        drain_reg <= 1'b0;
                        state_reg <= ST_PDRAIN;
                    end
                end
                ST_PDRAIN:
                begin
                    drain_reg <= 1'b1;
                    if (drain_reg)
                    begin
                        row_reg   <= '0;
                        dot_reg   <= '0;
                        k_reg     <= '0;
                        state_reg <= ST_ROW;
                    end
                end
                ST_ROW:
                begin
                    // advance k, then output column, then row
                    if (k_reg == 2'd2)
                    begin
                        k_reg <= '0;
                        if (dot_reg == 2'd3)
                        begin
                            dot_reg <= '0;
                            row_reg <= row_reg + 2'd1;
                            if (row_reg == 2'd2)
                            begin
                                drain_reg <= 1'b0;
                                state_reg <= ST_RDRAIN;
                            end
                        end
                        else
                        begin
                            dot_reg <= dot_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        k_reg <= k_reg + 2'd1;
                    end
                end
                ST_RDRAIN:
                begin
                    drain_reg <= 1'b1;
                    if (drain_reg)
                    begin
                        state_reg <= ST_COMMIT;
                    end
                end
                ST_COMMIT: state_reg <= ST_EMIT;
                ST_EMIT:
                begin
                    if (!status.last_joint || status.out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.asel   = A_CA;
        cmd.bsel   = B_SP;
        cmd.dst    = W_M3;
        cmd.accept = s_axis_tvalid && (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_RD_J:
            begin
                cmd.ram_rd = 1'b1;
            end
            ST_RD_A:
            begin
                cmd.lat_j    = 1'b1;
                cmd.ram_rd   = !status.first_joint;
                cmd.ram_prev = 1'b1;
            end
            ST_LAT_A:
            begin
                cmd.first_init = status.first_joint;
                cmd.lat_a      = !status.first_joint;
            end
            ST_COR_J:
            begin
                cmd.cor_start = 1'b1;
            end
            ST_COR_A:
            begin
                cmd.cor_start = 1'b1;
                cmd.cor_alpha = 1'b1;
            end
            ST_PROD:
            begin
                cmd.mac_issue = 1'b1;
                cmd.mac_first = 1'b1;
                cmd.mac_last  = 1'b1;
                unique case (pcnt_reg)
                    3'd1:
                    begin
                        cmd.asel = A_CA;
                        cmd.bsel = B_CP;
                        cmd.dst  = W_M4;
                    end
                    3'd2:
                    begin
                        cmd.asel = A_SA;
                        cmd.bsel = B_SP;
                        cmd.dst  = W_M6;
                    end
                    3'd3:
                    begin
                        cmd.asel = A_SA;
                        cmd.bsel = B_CP;
                        cmd.dst  = W_M7;
                    end
                    3'd4:
                    begin
                        cmd.asel = A_SA;
                        cmd.bsel = B_NEGD;
                        cmd.dst  = W_T1;
                    end
                    3'd5:
                    begin
                        cmd.asel = A_CA;
                        cmd.bsel = B_D;
                        cmd.dst  = W_T2;
                    end
                    default:
                    begin
                        cmd.asel = A_CA;
                        cmd.bsel = B_SP;
                        cmd.dst  = W_M3;
                    end
                endcase
            end
            ST_ROW:
            begin
                cmd.mac_issue = 1'b1;
                cmd.mac_first = (k_reg == 2'd0);
                cmd.mac_last  = (k_reg == 2'd2);
                cmd.asel      = A_ROT;
                cmd.ri        = {2'b00, row_reg} * 4'd3 + {2'b00, k_reg};
                cmd.mi        = {2'b00, k_reg} * 4'd3 + {2'b00, dot_reg};
                cmd.ti        = k_reg;
                if (dot_reg == 2'd3)
                begin
                    cmd.bsel = B_T;
                    cmd.dst  = W_POS;
                    cmd.widx = {2'b00, row_reg};
                end
                else
                begin
                    cmd.bsel = B_M;
                    cmd.dst  = W_NR;
                    cmd.widx = {2'b00, row_reg} * 4'd3 + {2'b00, dot_reg};
                end
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit = status.last_joint && status.out_free;
            end
            default: ;
        endcase
    end

endmodule

>>> rtl/dh_forward_kinematics_unit.sv
// Top level of the DH forward kinematics unit: controller plus datapath.
// Depends on dhfk_pkg, dhfk_ctrl and dhfk_datapath.
//
//  channel  dir  fields (tdata from bit 0 up)                      side bands
//  s_axis   in   segment_index, theta_offset, offset_d, length_a,   tuser: opcode
//                twist_alpha, joint_angle (120 bits)               tlast: last_joint
//  m_axis   out  rot_00..rot_22, pos_x, pos_y, pos_z (384 bits)    -
//
// A joint step runs two 30-step CORDIC runs on one iterative unit (one for joint 0) and
// 42 products through one shared multiply-accumulate. No clearing pass after reset: the
// pose resets at once. A result waits in the output register; a last-joint step that
// finishes while it is still held stalls until it is taken.
module dh_forward_kinematics_unit
    import dhfk_pkg::*;
#(
    parameter int NUM_JOINTS = NUM_JOINTS_DEF,
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // segment_index, theta_offset, offset_d, length_a, twist_alpha, joint_angle
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // opcode
    input  logic                   s_axis_tuser,
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22,
    // pos_x, pos_y, pos_z
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    dhfk_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    dhfk_datapath #(
        .NUM_JOINTS (NUM_JOINTS),
        .ANGLE_BITS (ANGLE_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
